### rtl/core/dssa_pkg.sv
// ----------------------------------------------------------------------------
// dssa_pkg
// Shared types and codes for the two-stacks-in-one-array block.
// ----------------------------------------------------------------------------
package dssa_pkg;

  // operation codes
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_PEEK = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // side codes
  localparam logic SIDE_A = 1'b0;
  localparam logic SIDE_B = 1'b1;

  // width of the reported fill levels
  localparam int FILL_W = 5;

  typedef struct packed {
    logic [1:0]         kind;
    logic               side;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic [FILL_W-1:0]  fill_a;
    logic [FILL_W-1:0]  fill_b;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_out;
  } dssa_cmd_t;

endpackage

### rtl/core/dssa_ctrl.sv
// ----------------------------------------------------------------------------
// dssa_ctrl
// Sequencer: takes a word, runs it through the store, hands the result to
// the output register and tracks its valid flag.
// ----------------------------------------------------------------------------
module dssa_ctrl
  import dssa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dssa_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  // output slot can take a new word this cycle
  assign slot_free = !out_valid_r || out_ready;

  // state sequencing and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // an accepted word is executed on the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> cmd.exec)
    else $error("accepted word not executed");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  // no new word while one is in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || (state_r == S_LOAD)) |-> !in_ready)
    else $error("input taken while busy");

endmodule

### rtl/core/dssa_dp.sv
// ----------------------------------------------------------------------------
// dssa_dp
// Datapath: item register, shared store, the two fill counters and the
// output register.
// ----------------------------------------------------------------------------
module dssa_dp
  import dssa_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dssa_cmd_t  cmd,
  input  in_item_t   in_data,
  output out_item_t  out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  in_item_t           item_r;
  logic [CW-1:0]      count_a_r, count_a_nxt;
  logic [CW-1:0]      count_b_r, count_b_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic               has_top_r, has_top_nxt;
  logic signed [31:0] rd_data_r;
  out_item_t          out_r;
  logic signed [31:0] store_mem [DEPTH];

  logic [CW:0]        total;
  logic               is_full;
  logic [CW-1:0]      fill_sel;
  logic [CW-1:0]      wr_idx, rd_idx;
  logic               wr_en;
  logic [CW+FILL_W-1:0] ext_a, ext_b;

  // item register
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  assign total    = {1'b0, count_a_r} + {1'b0, count_b_r};
  assign is_full  = (total >= {1'b0, DEPTH_C});
  assign fill_sel = (item_r.side == SIDE_A) ? count_a_r : count_b_r;

  // store addresses for each side
  assign wr_idx = (item_r.side == SIDE_A) ? count_a_r : (DEPTH_C - ONE_C - count_b_r);
  assign rd_idx = (item_r.side == SIDE_A) ? (count_a_r - ONE_C) : (DEPTH_C - count_b_r);

  // operation decode and counter update
  always_comb begin
    count_a_nxt    = count_a_r;
    count_b_nxt    = count_b_r;
    res_status_nxt = ST_OK;
    has_top_nxt    = 1'b0;
    wr_en          = 1'b0;
    case (item_r.kind)
      KIND_PUSH: begin
        if (is_full) begin
          res_status_nxt = ST_FULL;
        end else begin
          wr_en = 1'b1;
          if (item_r.side == SIDE_A) begin
            count_a_nxt = count_a_r + ONE_C;
          end else begin
            count_b_nxt = count_b_r + ONE_C;
          end
        end
      end
      KIND_POP, KIND_PEEK: begin
        if (fill_sel == '0) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          has_top_nxt = 1'b1;
          if (item_r.kind == KIND_POP) begin
            if (item_r.side == SIDE_A) begin
              count_a_nxt = count_a_r - ONE_C;
            end else begin
              count_b_nxt = count_b_r - ONE_C;
            end
          end
        end
      end
      default: begin
        res_status_nxt = ST_OK;
      end
    endcase
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r <= '0;
      count_b_r <= '0;
    end else if (cmd.exec) begin
      count_a_r <= count_a_nxt;
      count_b_r <= count_b_nxt;
    end
  end

  // shared store, one write or one registered read per word
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      store_mem[wr_idx[AW-1:0]] <= item_r.push_value;
    end else if (cmd.exec) begin
      rd_data_r <= store_mem[rd_idx[AW-1:0]];
    end
  end

  // per-word result flags
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      has_top_r    <= has_top_nxt;
    end
  end

  // low bits of the fill levels
  assign ext_a = {{FILL_W{1'b0}}, count_a_r};
  assign ext_b = {{FILL_W{1'b0}}, count_b_r};

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.status    <= res_status_r;
      out_r.top_value <= has_top_r ? rd_data_r : 32'sd0;
      out_r.fill_a    <= ext_a[FILL_W-1:0];
      out_r.fill_b    <= ext_b[FILL_W-1:0];
    end
  end

  assign out_data = out_r;

  // the two stacks never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    total <= {1'b0, DEPTH_C})
    else $error("stacks overlap");

  // a refused push leaves both counters alone
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (item_r.kind == KIND_PUSH) && is_full)
      |=> ($stable(count_a_r) && $stable(count_b_r)))
    else $error("counter moved on full push");

  // results without a top word carry zero
  a_zero_top: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && !has_top_r) |=> (out_r.top_value == 32'sd0))
    else $error("nonzero top value without a read");

endmodule

### rtl/core/dual_stack_shared_array.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_array
// Two LIFO stacks sharing one store: A grows up, B grows down.
// ----------------------------------------------------------------------------
// One word is in flight at a time. It is captured in the accepting cycle,
// in S_IDLE. S_EXEC then updates the fill counters and either writes the
// single-port store or reads it into a register. S_LOAD moves the result
// into the output register and sets its valid flag. A new word is taken
// only once the previous one has left S_LOAD, and S_LOAD stretches only
// while the previous result still waits at the output. The output register
// lets a new word be accepted while an earlier result is still waiting.
// The store needs no clearing after reset: only values from pushed entries
// ever reach the output. Fill levels are reported in their low five bits.
module dual_stack_shared_array
  import dssa_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  dssa_cmd_t cmd;

  // sequencer
  dssa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // store and counters
  dssa_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

### sim/dual_stack_shared_array_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_shared_array_tb
// Self-checking bench for the two-stacks-in-one-array block. A directed table
// walks the empty, full and extreme-value cases. Random traffic then swings
// both stacks between empty and full. Every reply is checked field by field
// against the table or an in-bench model; both handshakes stall at random.
// ----------------------------------------------------------------------------
module dual_stack_shared_array_tb;
  import dssa_pkg::*;

  localparam int DEPTH       = 16;
  localparam int RAND_WORDS  = 1130;
  localparam int N_DIR       = 26;
  localparam int TAIL_CYCLES = 12;
  localparam int DRAIN_LIMIT = 20000;
  // kind code that the block ignores
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // one row of the directed table; reply is used only when typed is set
  typedef struct {
    logic [1:0]         kind;
    logic               side;
    logic signed [31:0] value;
    int                 reps;
    bit                 typed;
    out_item_t          reply;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // model of both stacks
  logic signed [31:0] stack_mem [DEPTH];
  int                 depth_a = 0;
  int                 depth_b = 0;

  out_item_t due_replies [$];
  dir_row_t  dir_rows [N_DIR];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches = 0;
  int n_replies  = 0;
  int n_full     = 0;
  int n_empty    = 0;
  int n_kind [4] = '{0, 0, 0, 0};

  dual_stack_shared_array #(
    .DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // apply one operation to the stack model and return the reply it gives
  function automatic out_item_t apply_stack_op(input in_item_t w);
    out_item_t r;
    int        held;
    r = '0;
    r.status = ST_OK;
    case (w.kind)
      KIND_PUSH: begin
        if (depth_a + depth_b >= DEPTH) begin
          r.status = ST_FULL;
        end else if (w.side == SIDE_A) begin
          stack_mem[depth_a] = w.push_value;
          depth_a++;
        end else begin
          depth_b++;
          stack_mem[DEPTH - depth_b] = w.push_value;
        end
      end
      KIND_POP, KIND_PEEK: begin
        held = (w.side == SIDE_A) ? depth_a : depth_b;
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.top_value = (w.side == SIDE_A) ? stack_mem[depth_a - 1]
                                           : stack_mem[DEPTH - depth_b];
          if (w.kind == KIND_POP) begin
            if (w.side == SIDE_A) depth_a--;
            else depth_b--;
          end
        end
      end
      default: ;
    endcase
    r.fill_a = FILL_W'(depth_a);
    r.fill_b = FILL_W'(depth_b);
    return r;
  endfunction

  // offer one word with random gaps; on acceptance queue its reply
  task automatic offer_word(input in_item_t w, input bit typed, input out_item_t reply);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_stack_op(w);
    due_replies.push_back(typed ? reply : predicted);
    n_kind[w.kind]++;
    @(negedge clk);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // reply checker
  always @(posedge clk) begin : reply_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_replies.size() == 0) begin
        $error("reply with none due: status %0d top_value %0d", out_data.status,
               out_data.top_value);
        mismatches++;
      end else begin
        want = due_replies.pop_front();
        n_replies++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_EMPTY) n_empty++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.top_value !== want.top_value) begin
          $error("top_value: expected %0d, got %0d", want.top_value, out_data.top_value);
          mismatches++;
        end
        if (out_data.fill_a !== want.fill_a) begin
          $error("fill_a: expected %0d, got %0d", want.fill_a, out_data.fill_a);
          mismatches++;
        end
        if (out_data.fill_b !== want.fill_b) begin
          $error("fill_b: expected %0d, got %0d", want.fill_b, out_data.fill_b);
          mismatches++;
        end
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("dual_stack_shared_array_tb NOT OK");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    in_item_t           w;
    int                 n_done;
    int                 toward_full;
    int                 side_pct;
    int                 roll;
    int                 used;
    int                 waited;
    logic signed [31:0] picks [4];
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 60;
    picks = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1};

    // empty side reads and the ignored code right after reset
    dir_rows[0]  = '{KIND_POP,   SIDE_A, 32'sd0, 1, 1'b1, '{ST_EMPTY, 32'sd0, 5'd0, 5'd0}};
    dir_rows[1]  = '{KIND_PEEK,  SIDE_B, 32'sd0, 1, 1'b1, '{ST_EMPTY, 32'sd0, 5'd0, 5'd0}};
    dir_rows[2]  = '{KIND_POP,   SIDE_B, 32'sd0, 1, 1'b1, '{ST_EMPTY, 32'sd0, 5'd0, 5'd0}};
    dir_rows[3]  = '{KIND_PEEK,  SIDE_A, 32'sd0, 1, 1'b1, '{ST_EMPTY, 32'sd0, 5'd0, 5'd0}};
    dir_rows[4]  = '{KIND_SPARE, SIDE_A, -32'sd1, 1, 1'b1, '{ST_OK, 32'sd0, 5'd0, 5'd0}};
    // extreme values through both sides
    dir_rows[5]  = '{KIND_PUSH, SIDE_A, 32'sh7FFF_FFFF, 1, 1'b1, '{ST_OK, 32'sd0, 5'd1, 5'd0}};
    dir_rows[6]  = '{KIND_PUSH, SIDE_B, 32'sh8000_0000, 1, 1'b1, '{ST_OK, 32'sd0, 5'd1, 5'd1}};
    dir_rows[7]  = '{KIND_PEEK, SIDE_A, 32'sd0, 1, 1'b1,
                     '{ST_OK, 32'sh7FFF_FFFF, 5'd1, 5'd1}};
    dir_rows[8]  = '{KIND_PEEK, SIDE_B, 32'sd0, 1, 1'b1,
                     '{ST_OK, 32'sh8000_0000, 5'd1, 5'd1}};
    dir_rows[9]  = '{KIND_POP,  SIDE_A, 32'sd0, 1, 1'b1,
                     '{ST_OK, 32'sh7FFF_FFFF, 5'd0, 5'd1}};
    dir_rows[10] = '{KIND_POP,  SIDE_B, 32'sd0, 1, 1'b1,
                     '{ST_OK, 32'sh8000_0000, 5'd0, 5'd0}};
    dir_rows[11] = '{KIND_PUSH, SIDE_A, -32'sd1, 1, 1'b1, '{ST_OK, 32'sd0, 5'd1, 5'd0}};
    dir_rows[12] = '{KIND_PUSH, SIDE_B, 32'sd0, 1, 1'b1, '{ST_OK, 32'sd0, 5'd1, 5'd1}};
    // stacks meet in the middle
    dir_rows[13] = '{KIND_PUSH, SIDE_A, 32'sd0, 7, 1'b0, '{ST_OK, 32'sd0, 5'd0, 5'd0}};
    dir_rows[14] = '{KIND_PUSH, SIDE_B, 32'sd0, 7, 1'b0, '{ST_OK, 32'sd0, 5'd0, 5'd0}};
    dir_rows[15] = '{KIND_PUSH, SIDE_A, 32'sh5A5A_5A5A, 1, 1'b1,
                     '{ST_FULL, 32'sd0, 5'd8, 5'd8}};
    dir_rows[16] = '{KIND_PUSH, SIDE_B, 32'sh2C3D_4E5F, 1, 1'b1,
                     '{ST_FULL, 32'sd0, 5'd8, 5'd8}};
    dir_rows[17] = '{KIND_SPARE, SIDE_B, 32'sd7, 1, 1'b1, '{ST_OK, 32'sd0, 5'd8, 5'd8}};
    dir_rows[18] = '{KIND_PEEK, SIDE_B, 32'sd0, 1, 1'b0, '{ST_OK, 32'sd0, 5'd0, 5'd0}};
    dir_rows[19] = '{KIND_POP,  SIDE_A, 32'sd0, 8, 1'b0, '{ST_OK, 32'sd0, 5'd0, 5'd0}};
    dir_rows[20] = '{KIND_POP,  SIDE_A, 32'sd0, 1, 1'b1, '{ST_EMPTY, 32'sd0, 5'd0, 5'd8}};
    // one side alone takes the whole store
    dir_rows[21] = '{KIND_PUSH, SIDE_B, 32'sd0, 8, 1'b0, '{ST_OK, 32'sd0, 5'd0, 5'd0}};
    dir_rows[22] = '{KIND_PUSH, SIDE_A, 32'sd1, 1, 1'b1, '{ST_FULL, 32'sd0, 5'd0, 5'd16}};
    dir_rows[23] = '{KIND_POP,  SIDE_B, 32'sd0, 16, 1'b0, '{ST_OK, 32'sd0, 5'd0, 5'd0}};
    dir_rows[24] = '{KIND_PUSH, SIDE_A, 32'sd0, 16, 1'b0, '{ST_OK, 32'sd0, 5'd0, 5'd0}};
    dir_rows[25] = '{KIND_PUSH, SIDE_B, 32'sd2, 1, 1'b1, '{ST_FULL, 32'sd0, 5'd16, 5'd0}};

    // hold reset, then release it
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table; repeated rows carry random push values
    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        w.kind       = dir_rows[r].kind;
        w.side       = dir_rows[r].side;
        w.push_value = (dir_rows[r].reps > 1) ? $signed($urandom) : dir_rows[r].value;
        offer_word(w, dir_rows[r].typed, dir_rows[r].reply);
      end
    end

    // random traffic swinging the stacks between empty and full
    n_done      = 0;
    toward_full = 0;
    side_pct    = 50;
    while (n_done < RAND_WORDS) begin
      if (n_done == RAND_WORDS / 3) begin
        send_idle_pct = 60;
        recv_idle_pct = 29;
      end else if (n_done == 2 * RAND_WORDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      used = depth_a + depth_b;
      // turn around at the ends, after lingering there a little, or at random
      if ((toward_full != 0 && used == DEPTH && $urandom_range(99) < 40) ||
          (toward_full == 0 && used == 0 && $urandom_range(99) < 40) ||
          $urandom_range(99) < 2) begin
        toward_full = !toward_full;
        side_pct    = $urandom_range(2) * 50;
      end
      roll = $urandom_range(99);
      if (roll < 3) w.kind = KIND_SPARE;
      else if (roll < 68) w.kind = toward_full ? KIND_PUSH : KIND_POP;
      else if (roll < 84) w.kind = toward_full ? KIND_POP : KIND_PUSH;
      else w.kind = KIND_PEEK;
      w.side = ($urandom_range(99) < side_pct) ? SIDE_B : SIDE_A;
      w.push_value = ($urandom_range(99) < 10) ? picks[$urandom_range(3)] : $signed($urandom);
      offer_word(w, 1'b0, '0);
      if (w.kind != KIND_SPARE) n_done++;
    end
    in_valid <= 1'b0;

    // drain the outstanding replies
    waited = 0;
    while (due_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_replies.size() != 0) begin
      $error("%0d replies never arrived", due_replies.size());
      mismatches++;
    end

    $display("checked %0d replies: %0d push, %0d pop, %0d peek, %0d ignored-code words",
             n_replies, n_kind[KIND_PUSH], n_kind[KIND_POP], n_kind[KIND_PEEK],
             n_kind[KIND_SPARE]);
    $display("refused pushes on a full store: %0d, reads of an empty side: %0d",
             n_full, n_empty);
    if (mismatches == 0) begin
      $display("dual_stack_shared_array_tb OK");
    end else begin
      $display("dual_stack_shared_array_tb NOT OK");
    end
    $finish;
  end

endmodule
